// ===== hw/rtl/shne_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shne_pkg
// Constants, codes and key-map lookup for the scancode hex number entry block.
// ----------------------------------------------------------------------------
package shne_pkg;

  localparam int ACC_WIDTH   = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int SCAN_WIDTH  = 8;
  localparam int DIGIT_WIDTH = 4;

  typedef logic [SCAN_WIDTH-1:0]  scan_t;
  typedef logic [ACC_WIDTH-1:0]   acc_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [DIGIT_WIDTH-1:0] digit_t;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2,
    WSEL_64 = 2'd3
  } wsel_t;

  localparam wsel_t WSEL_RESET = WSEL_64;

  localparam scan_t SC_SHIFT_MAKE  = 8'h2A;
  localparam scan_t SC_SHIFT_BREAK = 8'hAA;
  localparam scan_t SC_ENTER       = 8'h1C;
  localparam scan_t SC_BACKSPACE   = 8'h0E;

  typedef struct packed {
    logic   hit;
    digit_t digit;
  } key_digit_t;

  // Unshifted set-1 key map, restricted to keys that give a hex digit.
  function automatic key_digit_t key_to_digit(scan_t code);
    key_digit_t r;
    r.hit   = 1'b1;
    r.digit = '0;
    unique case (code) inside
      [8'h02:8'h0A]: r.digit = DIGIT_WIDTH'(code - 8'd1);
      8'h0B:         r.digit = 4'h0;
      8'h1E:         r.digit = 4'hA;
      8'h30:         r.digit = 4'hB;
      8'h2E:         r.digit = 4'hC;
      8'h20:         r.digit = 4'hD;
      8'h12:         r.digit = 4'hE;
      8'h21:         r.digit = 4'hF;
      default:       r.hit   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/scancode_hex_number_entry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_hex_number_entry
// Builds a hex number from PS/2 set-1 scancodes; Enter emits it truncated.
//
// channel  dir  tdata                   tuser
// in_      in   [7:0] scan_byte         -
// out_     out  [63:0] value            [0] done_res
// cfg_     in   cfg_wdata[1:0] width_select (write when cfg_we)
//
// One transaction per cycle sustained while the output is not stalled; a byte
// passes the input register, then the result register. Key state updates
// when a byte moves into the result register. A stalled output holds its
// result while one more byte waits in the input register. Synchronous
// active-low reset clears shift, accumulator and width_select (to 64 bits).
// ----------------------------------------------------------------------------
module scancode_hex_number_entry
  import shne_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] value
  output logic [0:0]  out_tuser,  // [0] done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  logic       s1_vld_r;
  scan_t      s1_byte_r;
  logic       out_vld_r;
  value_t     out_value_r;
  logic       out_done_r;
  logic       shift_r;
  logic       shift_nxt;
  acc_t       acc_r;
  acc_t       acc_nxt;
  wsel_t      wsel_r;
  value_t     value_nxt;
  logic       done_nxt;
  logic       out_free;
  logic       s1_move;
  key_digit_t kd;
  value_t     acc_ext;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_move   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || s1_move;

  assign kd      = key_to_digit(s1_byte_r);
  assign acc_ext = VALUE_WIDTH'(acc_r);

  always_comb begin
    shift_nxt = shift_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    if (s1_byte_r == SC_SHIFT_MAKE) begin
      shift_nxt = 1'b1;
    end else if (s1_byte_r == SC_SHIFT_BREAK) begin
      shift_nxt = 1'b0;
    end else if (s1_byte_r[SCAN_WIDTH-1]) begin
      // other releases ignored
    end else if (s1_byte_r == SC_ENTER) begin
      done_nxt = 1'b1;
      acc_nxt  = '0;
    end else if (s1_byte_r == SC_BACKSPACE) begin
      acc_nxt = acc_r >> DIGIT_WIDTH;
    end else if (!shift_r && kd.hit) begin
      acc_nxt = {acc_r[ACC_WIDTH-DIGIT_WIDTH-1:0], kd.digit};
    end

    if (done_nxt) begin
      unique case (wsel_r)
        WSEL_8:  value_nxt = acc_ext & VALUE_WIDTH'(64'h0000_0000_0000_00FF);
        WSEL_16: value_nxt = acc_ext & VALUE_WIDTH'(64'h0000_0000_0000_FFFF);
        WSEL_32: value_nxt = acc_ext & VALUE_WIDTH'(64'h0000_0000_FFFF_FFFF);
        default: value_nxt = acc_ext;
      endcase
    end else begin
      value_nxt = VALUE_WIDTH'(acc_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      shift_r   <= 1'b0;
      acc_r     <= '0;
      wsel_r    <= WSEL_RESET;
    end else begin
      if (cfg_we) begin
        wsel_r <= wsel_t'(cfg_wdata);
      end
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s1_move) begin
        shift_r <= shift_nxt;
        acc_r   <= acc_nxt;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_move) begin
      out_value_r <= value_nxt;
      out_done_r  <= done_nxt;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_done_r;

endmodule
